FILE: hw/rtl/mcla_pkg.sv
// package: table sizes, lags, key map and shared types of the lagged-adder cipher
`default_nettype none

package mcla_pkg;

    // generator table sizes
    localparam int unsigned SIZE_ONE   = 55;
    localparam int unsigned SIZE_TWO   = 57;
    localparam int unsigned SIZE_THREE = 58;

    // generator lags
    localparam int unsigned LAG_ONE   = 31;
    localparam int unsigned LAG_TWO   = 50;
    localparam int unsigned LAG_THREE = 39;

    // key index map
    localparam int unsigned KEY_WORDS  = SIZE_ONE + SIZE_TWO + SIZE_THREE;
    localparam int unsigned BASE_TWO   = SIZE_ONE;
    localparam int unsigned BASE_THREE = SIZE_ONE + SIZE_TWO;

    // operation codes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // widths
    localparam int unsigned IDX_W  = 6;
    localparam int unsigned WORD_W = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [WORD_W-1:0] word_t;
    typedef logic [1:0]        bpos_t;

    // data byte held between the table read and the result register
    typedef struct packed {
        logic [7:0] data;
        logic       eob;
        bpos_t      pos;
    } item_t;

endpackage : mcla_pkg

`default_nettype wire

FILE: hw/rtl/majority_clocked_lagged_adder_cipher.sv
// top level: majority-clocked lagged-adder byte stream cipher
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer. With
//   operation = load the key word is written at key_index (0..169); any valid
//   load also clears indices, carries, partial sums and byte position. A load
//   above 169 is dropped. Loads give no result. All 170 words must be loaded
//   before data. With operation = data one byte is XORed with the keystream
//   and one result leaves on the output channel (out_valid / out_stall).
//   A data byte taken in goes to the stage register, then the output register.
//   Throughput: one item per cycle unless out_stall holds a result; the three
//   tables are read at i and i+lag through registered two-port reads at
//   transfer, and the word is summed from them, once every four bytes.
//   Reset: asynchronous, active low; clears pipeline valid flags and the
//   generator state. Table contents are not cleared and stay undefined until
//   loaded.
//   Stall: when out_stall holds a waiting result, the staged byte keeps its
//   place and in_stall rises only if both the stage and the output are full.
`default_nettype none

module majority_clocked_lagged_adder_cipher
    import mcla_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        operation,
    input  wire logic [7:0]  key_index,
    input  wire logic [31:0] key_word,
    input  wire logic [7:0]  data_byte,
    input  wire logic        end_of_buffer,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [7:0]       out_byte,
    output logic             end_of_buffer_out
);

    // generator tables
    word_t tab_one   [SIZE_ONE];
    word_t tab_two   [SIZE_TWO];
    word_t tab_three [SIZE_THREE];

    // registered table reads at i and i+lag
    word_t rd_a_one_reg, rd_b_one_reg;
    word_t rd_a_two_reg, rd_b_two_reg;
    word_t rd_a_three_reg, rd_b_three_reg;

    // generator state
    idx_t  idx_one_reg, idx_two_reg, idx_three_reg;
    idx_t  idx_one_next, idx_two_next, idx_three_next;
    logic  carry_one_reg, carry_two_reg, carry_three_reg;
    logic  carry_one_next, carry_two_next, carry_three_next;
    word_t part_one_reg, part_two_reg, part_three_reg;
    word_t part_one_next, part_two_next, part_three_next;
    word_t ks_word_reg, ks_word_next;
    bpos_t pos_reg, pos_next;

    // staged item and output register
    logic  s1_valid_reg, s1_valid_next;
    item_t s1_item_reg;
    logic  out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg;
    logic  eob_out_reg;

    // handshake
    logic in_accept, data_acc, load_acc, s1_adv, new_word;

    // second read addresses and incremented indices
    logic [IDX_W:0] j_one_sum, j_two_sum, j_three_sum;
    idx_t  j_one, j_two, j_three;
    idx_t  inc_one, inc_two, inc_three;

    // generator step
    logic  maj, clk_one, clk_two, clk_three;
    logic [WORD_W:0] sum_one, sum_two, sum_three;
    word_t word_new, ks_sel;
    logic [7:0] ks_byte;

    // key write decode
    logic  wr_one, wr_two, wr_three;
    logic [7:0] addr_two_full, addr_three_full;

    // transfer control
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign data_acc  = in_accept && (operation == OP_DATA);
    assign load_acc  = in_accept && (operation == OP_LOAD)
                       && (key_index < 8'(KEY_WORDS));
    assign new_word  = (s1_item_reg.pos == 2'd0);

    // second read address, i + lag wrapped once
    assign j_one_sum   = {1'b0, idx_one_reg} + 7'(LAG_ONE);
    assign j_two_sum   = {1'b0, idx_two_reg} + 7'(LAG_TWO);
    assign j_three_sum = {1'b0, idx_three_reg} + 7'(LAG_THREE);
    assign j_one   = (j_one_sum >= 7'(SIZE_ONE)) ?
                     IDX_W'(j_one_sum - 7'(SIZE_ONE)) : j_one_sum[IDX_W-1:0];
    assign j_two   = (j_two_sum >= 7'(SIZE_TWO)) ?
                     IDX_W'(j_two_sum - 7'(SIZE_TWO)) : j_two_sum[IDX_W-1:0];
    assign j_three = (j_three_sum >= 7'(SIZE_THREE)) ?
                     IDX_W'(j_three_sum - 7'(SIZE_THREE)) : j_three_sum[IDX_W-1:0];

    // index advance with wrap
    assign inc_one   = (idx_one_reg == IDX_W'(SIZE_ONE - 1)) ? '0 : idx_one_reg + 1'b1;
    assign inc_two   = (idx_two_reg == IDX_W'(SIZE_TWO - 1)) ? '0 : idx_two_reg + 1'b1;
    assign inc_three = (idx_three_reg == IDX_W'(SIZE_THREE - 1)) ?
                       '0 : idx_three_reg + 1'b1;

    // key write decode
    assign addr_two_full   = key_index - 8'(BASE_TWO);
    assign addr_three_full = key_index - 8'(BASE_THREE);
    assign wr_one   = load_acc && (key_index < 8'(BASE_TWO));
    assign wr_two   = load_acc && (key_index >= 8'(BASE_TWO))
                      && (key_index < 8'(BASE_THREE));
    assign wr_three = load_acc && (key_index >= 8'(BASE_THREE));

    // table writes
    always_ff @(posedge clk)
    begin
        if (wr_one)
        begin
            tab_one[key_index[IDX_W-1:0]] <= key_word;
        end
        if (wr_two)
        begin
            tab_two[addr_two_full[IDX_W-1:0]] <= key_word;
        end
        if (wr_three)
        begin
            tab_three[addr_three_full[IDX_W-1:0]] <= key_word;
        end
    end

    // table reads, taken with each data transfer
    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            rd_a_one_reg   <= tab_one[idx_one_reg];
            rd_b_one_reg   <= tab_one[j_one];
            rd_a_two_reg   <= tab_two[idx_two_reg];
            rd_b_two_reg   <= tab_two[j_two];
            rd_a_three_reg <= tab_three[idx_three_reg];
            rd_b_three_reg <= tab_three[j_three];
        end
    end

    // majority clocking and lagged sums
    always_comb
    begin
        maj       = (carry_one_reg & carry_two_reg)
                    | (carry_three_reg & (carry_one_reg | carry_two_reg));
        clk_one   = (carry_one_reg == maj);
        clk_two   = (carry_two_reg == maj);
        clk_three = (carry_three_reg == maj);
        sum_one   = {1'b0, rd_a_one_reg} + {1'b0, rd_b_one_reg};
        sum_two   = {1'b0, rd_a_two_reg} + {1'b0, rd_b_two_reg};
        sum_three = {1'b0, rd_a_three_reg} + {1'b0, rd_b_three_reg};
        word_new  = (clk_one ? sum_one[WORD_W-1:0] : part_one_reg)
                    ^ (clk_two ? sum_two[WORD_W-1:0] : part_two_reg)
                    ^ (clk_three ? sum_three[WORD_W-1:0] : part_three_reg);
        ks_sel    = new_word ? word_new : ks_word_reg;
    end

    // little-endian keystream byte
    always_comb
    begin
        case (s1_item_reg.pos)
            2'd0:    ks_byte = ks_sel[7:0];
            2'd1:    ks_byte = ks_sel[15:8];
            2'd2:    ks_byte = ks_sel[23:16];
            default: ks_byte = ks_sel[31:24];
        endcase
    end

    // generator state next values, key load clear wins
    always_comb
    begin
        idx_one_next     = idx_one_reg;
        idx_two_next     = idx_two_reg;
        idx_three_next   = idx_three_reg;
        carry_one_next   = carry_one_reg;
        carry_two_next   = carry_two_reg;
        carry_three_next = carry_three_reg;
        part_one_next    = part_one_reg;
        part_two_next    = part_two_reg;
        part_three_next  = part_three_reg;
        ks_word_next     = ks_word_reg;
        pos_next         = pos_reg;
        if (load_acc)
        begin
            idx_one_next     = '0;
            idx_two_next     = '0;
            idx_three_next   = '0;
            carry_one_next   = 1'b0;
            carry_two_next   = 1'b0;
            carry_three_next = 1'b0;
            part_one_next    = '0;
            part_two_next    = '0;
            part_three_next  = '0;
            ks_word_next     = '0;
            pos_next         = '0;
        end
        else
        begin
            if (data_acc)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (s1_adv && new_word)
            begin
                ks_word_next = word_new;
                if (clk_one)
                begin
                    idx_one_next   = inc_one;
                    carry_one_next = sum_one[WORD_W];
                    part_one_next  = sum_one[WORD_W-1:0];
                end
                if (clk_two)
                begin
                    idx_two_next   = inc_two;
                    carry_two_next = sum_two[WORD_W];
                    part_two_next  = sum_two[WORD_W-1:0];
                end
                if (clk_three)
                begin
                    idx_three_next   = inc_three;
                    carry_three_next = sum_three[WORD_W];
                    part_three_next  = sum_three[WORD_W-1:0];
                end
            end
        end
    end

    // pipeline valid next values
    always_comb
    begin
        s1_valid_next  = data_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_reg);
        out_valid_next = s1_adv ? 1'b1 : (out_stall ? out_valid_reg : 1'b0);
    end

    // control and generator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            idx_one_reg     <= '0;
            idx_two_reg     <= '0;
            idx_three_reg   <= '0;
            carry_one_reg   <= 1'b0;
            carry_two_reg   <= 1'b0;
            carry_three_reg <= 1'b0;
            part_one_reg    <= '0;
            part_two_reg    <= '0;
            part_three_reg  <= '0;
            ks_word_reg     <= '0;
            pos_reg         <= '0;
        end
        else
        begin
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
            idx_one_reg     <= idx_one_next;
            idx_two_reg     <= idx_two_next;
            idx_three_reg   <= idx_three_next;
            carry_one_reg   <= carry_one_next;
            carry_two_reg   <= carry_two_next;
            carry_three_reg <= carry_three_next;
            part_one_reg    <= part_one_next;
            part_two_reg    <= part_two_next;
            part_three_reg  <= part_three_next;
            ks_word_reg     <= ks_word_next;
            pos_reg         <= pos_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (data_acc)
        begin
            s1_item_reg.data <= data_byte;
            s1_item_reg.eob  <= end_of_buffer;
            s1_item_reg.pos  <= pos_reg;
        end
        if (s1_adv)
        begin
            out_byte_reg <= s1_item_reg.data ^ ks_byte;
            eob_out_reg  <= s1_item_reg.eob;
        end
    end

    // outputs
    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign end_of_buffer_out = eob_out_reg;

`ifndef SYNTH
    // input stalls only behind a full stage
    a_stall_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("in_stall without a blocked stage");

    // read indices stay inside their tables
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_one_reg < IDX_W'(SIZE_ONE)) && (idx_two_reg < IDX_W'(SIZE_TWO))
        && (idx_three_reg < IDX_W'(SIZE_THREE)))
        else $error("read index out of range");

    // a key load leaves the generators cleared
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load_acc |=> (pos_reg == 2'd0) && (idx_one_reg == '0) && !carry_one_reg
                     && !carry_two_reg && !carry_three_reg && (ks_word_reg == '0))
        else $error("key load did not clear generator state");

    // a new result comes only from the staged byte
    a_out_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_valid_reg))
        else $error("result without a staged byte");
`endif

endmodule : majority_clocked_lagged_adder_cipher

`default_nettype wire
